// ===== src/i2csrm_pkg.sv =====
// Package for the I2C slave register map: event codes, constants and the
// structs passed between the configuration, core and top-level modules.
// No dependencies.
package i2csrm_pkg;

   localparam int OFFSET_W = 4;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [2:0] {
      FUNC_ADDR_MATCH = 3'd0,
      FUNC_TX_REQ     = 3'd1,
      FUNC_RX_BYTE    = 3'd2,
      FUNC_NACK       = 3'd3,
      FUNC_STOP       = 3'd4,
      FUNC_BUS_ERROR  = 3'd5
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_ADDRESS = 2'd0,
      CSR_SEND_WORD_0   = 2'd1,
      CSR_SEND_WORD_1   = 2'd2,
      CSR_SEND_WORD_2   = 2'd3
   } csr_index_type;

   localparam logic [7:0]  EMPTY_BLOCK_BYTE  = 8'hFA;
   localparam logic [7:0]  PAST_END_BYTE     = 8'hFB;
   localparam logic [31:0] SEND_WORD_0_RESET = 32'h2322_2120;
   localparam logic [31:0] SEND_WORD_1_RESET = 32'h2726_2524;
   localparam logic [31:0] SEND_WORD_2_RESET = 32'h0000_2928;

   typedef struct packed {
      logic [7:0]  block_address;
      logic [31:0] send_word_0;
      logic [31:0] send_word_1;
      logic [31:0] send_word_2;
   } cfg_type;

   typedef struct packed {
      logic [2:0] func;
      logic       master_reads;
      logic [7:0] rx_byte;
   } event_type;

   typedef struct packed {
      logic [7:0]          tx_byte;
      logic                store_write;
      logic [OFFSET_W-1:0] store_index;
      logic [7:0]          store_byte;
      logic                sending;
      logic                nack_seen;
      logic                error_seen;
      logic [OFFSET_W-1:0] received_count;
      logic [OFFSET_W-1:0] sent_count;
   } result_type;

endpackage

// ===== src/i2c_slave_register_map.sv =====
// I2C slave register map: one bus event in, one result beat out.
// Path: request beat, input register, event logic, result register, result beat.
// Throughput: one event per cycle unless rsp_ready stalls; event logic is a single pass between the two registers.
// A request beat is taken while a result waits, as long as the input register is empty or can drain.
// Reset is synchronous, active high: clears state, flags, lengths and restores table defaults.
// Depends on i2csrm_pkg, i2csrm_csr and i2csrm_core.
module i2c_slave_register_map import i2csrm_pkg::*; #(
   parameter int TABLE_SIZE = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_func,
   input  logic                 req_master_reads,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_tx_byte,
   output logic                 rsp_store_write,
   output logic [3:0]           rsp_store_index,
   output logic [7:0]           rsp_store_byte,
   output logic                 rsp_sending,
   output logic                 rsp_nack_seen,
   output logic                 rsp_error_seen,
   output logic [3:0]           rsp_received_count,
   output logic [3:0]           rsp_sent_count,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   cfg_type    cfg;
   event_type  evt_ff;
   logic       evt_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign advance   = evt_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !evt_valid_ff || advance;

   i2csrm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   i2csrm_core #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .evt    (evt_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            evt_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         evt_ff.func         <= req_func;
         evt_ff.master_reads <= req_master_reads;
         evt_ff.rx_byte      <= req_rx_byte;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tx_byte        = rsp_ff.tx_byte;
   assign rsp_store_write    = rsp_ff.store_write;
   assign rsp_store_index    = rsp_ff.store_index;
   assign rsp_store_byte     = rsp_ff.store_byte;
   assign rsp_sending        = rsp_ff.sending;
   assign rsp_nack_seen      = rsp_ff.nack_seen;
   assign rsp_error_seen     = rsp_ff.error_seen;
   assign rsp_received_count = rsp_ff.received_count;
   assign rsp_sent_count     = rsp_ff.sent_count;

   // a store write and a transmit byte never come from the same event
   a_write_no_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_write |-> rsp_tx_byte == 8'h00)
      else $error("store write beat carries a transmit byte");

   a_index_in_table: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_write |-> rsp_store_index < 4'(TABLE_SIZE))
      else $error("store index beyond table");

   // a latched receive length holds for every later beat
   a_length_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_received_count != 4'd0
      |=> !rsp_valid || rsp_received_count == $past(rsp_received_count))
      else $error("latched receive length changed");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side not ready after reset");

endmodule

// ===== src/i2csrm_csr.sv =====
// Configuration registers of the I2C slave register map: block address
// and the three send table words. Depends on i2csrm_pkg.
module i2csrm_csr import i2csrm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLOCK_ADDRESS: cfg_in.block_address = csr_data[7:0];
            CSR_SEND_WORD_0:   cfg_in.send_word_0   = csr_data;
            CSR_SEND_WORD_1:   cfg_in.send_word_1   = csr_data;
            CSR_SEND_WORD_2:   cfg_in.send_word_2   = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_address <= '0;
         cfg_ff.send_word_0   <= SEND_WORD_0_RESET;
         cfg_ff.send_word_1   <= SEND_WORD_1_RESET;
         cfg_ff.send_word_2   <= SEND_WORD_2_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/i2csrm_core.sv =====
// Bus event logic and transfer state of the I2C slave register map:
// block select, offset, sticky flags and latched lengths. Depends on i2csrm_pkg.
module i2csrm_core import i2csrm_pkg::*; #(
   parameter int TABLE_SIZE = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  event_type  evt,
   input  cfg_type    cfg,
   output result_type result
);

   localparam logic [OFFSET_W-1:0] TABLE_END = OFFSET_W'(TABLE_SIZE);

   logic                address_taken_ff, address_taken_in;
   logic [7:0]          selected_block_ff, selected_block_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                direction_send_ff, direction_send_in;
   logic                nack_flag_ff, nack_flag_in;
   logic                error_flag_ff, error_flag_in;
   logic [OFFSET_W-1:0] receive_length_ff, receive_length_in;
   logic [OFFSET_W-1:0] send_length_ff, send_length_in;

   logic                block_hit;
   logic                in_table;
   logic [OFFSET_W-1:0] offset_inc;
   logic [OFFSET_W-1:0] offset_next;
   logic [31:0]         word;
   logic [7:0]          table_byte;

   assign block_hit  = (selected_block_ff == cfg.block_address);
   assign in_table   = (offset_ff < TABLE_END);
   assign offset_inc = offset_ff + 1'b1;
   assign offset_next = (offset_inc >= TABLE_END) ? '0 : offset_inc;

   // byte lane select in the send table; word three folds back onto word zero
   always_comb begin
      case (offset_ff[3:2])
         2'd1:    word = cfg.send_word_1;
         2'd2:    word = cfg.send_word_2;
         default: word = cfg.send_word_0;
      endcase
      case (offset_ff[1:0])
         2'd1:    table_byte = word[15:8];
         2'd2:    table_byte = word[23:16];
         2'd3:    table_byte = word[31:24];
         default: table_byte = word[7:0];
      endcase
   end

   always_comb begin
      address_taken_in  = address_taken_ff;
      selected_block_in = selected_block_ff;
      offset_in         = offset_ff;
      direction_send_in = direction_send_ff;
      nack_flag_in      = nack_flag_ff;
      error_flag_in     = error_flag_ff;
      receive_length_in = receive_length_ff;
      send_length_in    = send_length_ff;
      result            = '0;

      unique case (evt.func)
         FUNC_ADDR_MATCH: begin
            direction_send_in = evt.master_reads;
            if (!evt.master_reads) begin
               address_taken_in = 1'b0;
            end
         end
         FUNC_TX_REQ: begin
            if (!block_hit) begin
               result.tx_byte = EMPTY_BLOCK_BYTE;
            end else if (!in_table) begin
               result.tx_byte = PAST_END_BYTE;
            end else begin
               result.tx_byte = table_byte;
               offset_in      = offset_next;
            end
         end
         FUNC_RX_BYTE: begin
            if (!address_taken_ff) begin
               // first byte after the address selects the block
               selected_block_in = evt.rx_byte;
               offset_in         = '0;
               address_taken_in  = 1'b1;
            end else if (block_hit && in_table) begin
               result.store_write = 1'b1;
               result.store_index = offset_ff;
               result.store_byte  = evt.rx_byte;
               offset_in          = offset_next;
            end
         end
         FUNC_NACK: begin
            address_taken_in = 1'b0;
            nack_flag_in     = 1'b1;
         end
         FUNC_STOP: begin
            address_taken_in = 1'b0;
            if (!direction_send_ff) begin
               if (receive_length_ff == '0) begin
                  receive_length_in = offset_ff;
               end
            end else if (send_length_ff == '0) begin
               send_length_in = offset_ff;
            end
         end
         FUNC_BUS_ERROR: begin
            error_flag_in = 1'b1;
         end
         default: begin
         end
      endcase

      result.sending        = direction_send_in;
      result.nack_seen      = nack_flag_in;
      result.error_seen     = error_flag_in;
      result.received_count = receive_length_in;
      result.sent_count     = send_length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_taken_ff  <= 1'b0;
         selected_block_ff <= '0;
         offset_ff         <= '0;
         direction_send_ff <= 1'b0;
         nack_flag_ff      <= 1'b0;
         error_flag_ff     <= 1'b0;
         receive_length_ff <= '0;
         send_length_ff    <= '0;
      end else if (fire) begin
         address_taken_ff  <= address_taken_in;
         selected_block_ff <= selected_block_in;
         offset_ff         <= offset_in;
         direction_send_ff <= direction_send_in;
         nack_flag_ff      <= nack_flag_in;
         error_flag_ff     <= error_flag_in;
         receive_length_ff <= receive_length_in;
         send_length_ff    <= send_length_in;
      end
   end

endmodule
